### rtl/bpqm_pkg.sv
// Shared types and codes for the buffer pool queue manager.
// No dependencies; imported by bpqm_core and buffer_pool_queue_manager.
package bpqm_pkg;

    // Fixed widths of the item fields.
    localparam int OP_W     = 2;
    localparam int LEN_W    = 13;
    localparam int SLOT_W   = 4;
    localparam int STATUS_W = 3;

    // Operation codes.
    typedef enum logic [OP_W-1:0] {
        OP_PUT      = 2'd0,
        OP_TAKE     = 2'd1,
        OP_COMPLETE = 2'd2,
        OP_STOP     = 2'd3
    } op_t;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_FULL     = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_FINISHED = 3'd3,
        ST_REJECT   = 3'd4
    } status_t;

    // One result of one operation.
    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic [LEN_W-1:0]  length;
        status_t           status;
    } result_t;

endpackage

### rtl/bpqm_core.sv
// Slot bookkeeping: free FIFO, filled FIFO with lengths, held slot, stop flag.
// Executes one operation per cycle when exec is high. Depends on bpqm_pkg.
module bpqm_core #(
    parameter int QUEUE_SLOTS  = 16,
    parameter int BUFFER_BYTES = 4096
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           exec,
    input  bpqm_pkg::op_t                  op,
    input  logic [bpqm_pkg::LEN_W-1:0]     length,
    output bpqm_pkg::result_t              res
);
    import bpqm_pkg::*;

    localparam int SW = (QUEUE_SLOTS > 1) ? $clog2(QUEUE_SLOTS) : 1;
    localparam int CW = $clog2(QUEUE_SLOTS + 1);
    localparam logic [SW-1:0] LAST_IDX = SW'(QUEUE_SLOTS - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(QUEUE_SLOTS);
    localparam logic [31:0]   BUF_MAX  = 32'(BUFFER_BYTES);

    // Pointer arithmetic modulo the pool size.
    function automatic logic [SW-1:0] ptr_inc(input logic [SW-1:0] p);
        return (p == LAST_IDX) ? '0 : p + SW'(1);
    endfunction

    function automatic logic [SW-1:0] ptr_dec(input logic [SW-1:0] p);
        return (p == '0) ? LAST_IDX : p - SW'(1);
    endfunction

    function automatic logic [SLOT_W-1:0] out_slot(input logic [SW-1:0] s);
        logic [31:0] w;
        w = 32'(s);
        return w[SLOT_W-1:0];
    endfunction

    // Storage arrays.
    logic [SW-1:0]     free_fifo_reg   [QUEUE_SLOTS];
    logic [QUEUE_SLOTS-1:0] free_written_reg, free_written_next;
    logic [SW-1:0]     filled_fifo_reg [QUEUE_SLOTS];
    logic [LEN_W-1:0]  filled_len_reg  [QUEUE_SLOTS];

    // Control registers.
    logic [SW-1:0] free_head_reg, free_head_next;
    logic [SW-1:0] free_tail_reg, free_tail_next;
    logic [CW-1:0] free_count_reg, free_count_next;
    logic [SW-1:0] filled_head_reg, filled_head_next;
    logic [SW-1:0] filled_tail_reg, filled_tail_next;
    logic [CW-1:0] filled_count_reg, filled_count_next;
    logic [SW-1:0] newest_slot_reg, newest_slot_next;
    logic [SW-1:0] held_slot_reg, held_slot_next;
    logic          held_valid_reg, held_valid_next;
    logic          stop_reg, stop_next;

    // Array write controls.
    logic          free_wr_en;
    logic [SW-1:0] free_wr_idx;
    logic [SW-1:0] free_wr_slot;
    logic          filled_wr_en;
    logic [SW-1:0] filled_wr_slot;
    logic          len_wr_en;
    logic [SW-1:0] len_wr_idx;

    logic [SW-1:0]    free_head_slot;
    logic [SW-1:0]    filled_head_slot;
    logic [LEN_W-1:0] len_sat;

    // An entry of the free FIFO that was never written reads as its own index.
    assign free_head_slot   = free_written_reg[free_head_reg] ? free_fifo_reg[free_head_reg]
                                                              : free_head_reg;
    assign filled_head_slot = filled_fifo_reg[filled_head_reg];

    // Lengths above the buffer size saturate to it.
    assign len_sat = (32'(length) > BUF_MAX) ? BUF_MAX[LEN_W-1:0] : length;

    // Operation decode and next state.
    always_comb
    begin
        free_head_next    = free_head_reg;
        free_tail_next    = free_tail_reg;
        free_count_next   = free_count_reg;
        free_written_next = free_written_reg;
        filled_head_next  = filled_head_reg;
        filled_tail_next  = filled_tail_reg;
        filled_count_next = filled_count_reg;
        newest_slot_next  = newest_slot_reg;
        held_slot_next    = held_slot_reg;
        held_valid_next   = held_valid_reg;
        stop_next         = stop_reg;
        free_wr_en        = 1'b0;
        free_wr_idx       = free_tail_reg;
        free_wr_slot      = held_slot_reg;
        filled_wr_en      = 1'b0;
        filled_wr_slot    = free_head_slot;
        len_wr_en         = 1'b0;
        len_wr_idx        = filled_tail_reg;
        res               = '0;
        res.status        = ST_OK;

        unique case (op)
            OP_PUT:
            begin
                if (free_count_reg != '0 && filled_count_reg < FULL_CNT)
                begin
                    free_head_next    = ptr_inc(free_head_reg);
                    free_count_next   = free_count_reg - CW'(1);
                    filled_wr_en      = 1'b1;
                    len_wr_en         = 1'b1;
                    filled_tail_next  = ptr_inc(filled_tail_reg);
                    filled_count_next = filled_count_reg + CW'(1);
                    newest_slot_next  = free_head_slot;
                    res.slot          = out_slot(free_head_slot);
                end
                else if (filled_count_reg != '0)
                begin
                    // No free slot: the newest filled slot takes the new length.
                    len_wr_en  = 1'b1;
                    len_wr_idx = ptr_dec(filled_tail_reg);
                    res.slot   = out_slot(newest_slot_reg);
                    res.status = ST_FULL;
                end
                else
                begin
                    res.status = ST_REJECT;
                end
            end
            OP_TAKE:
            begin
                if (held_valid_reg)
                begin
                    res.status = ST_REJECT;
                end
                else if (filled_count_reg == '0)
                begin
                    res.status = stop_reg ? ST_FINISHED : ST_EMPTY;
                end
                else
                begin
                    filled_head_next  = ptr_inc(filled_head_reg);
                    filled_count_next = filled_count_reg - CW'(1);
                    held_slot_next    = filled_head_slot;
                    held_valid_next   = 1'b1;
                    res.slot          = out_slot(filled_head_slot);
                    res.length        = filled_len_reg[filled_head_reg];
                end
            end
            OP_COMPLETE:
            begin
                if (!held_valid_reg || free_count_reg >= FULL_CNT)
                begin
                    res.status = ST_REJECT;
                end
                else
                begin
                    free_wr_en                       = 1'b1;
                    free_written_next[free_tail_reg] = 1'b1;
                    free_tail_next                   = ptr_inc(free_tail_reg);
                    free_count_next                  = free_count_reg + CW'(1);
                    held_valid_next                  = 1'b0;
                    res.slot                         = out_slot(held_slot_reg);
                end
            end
            OP_STOP:
            begin
                stop_next = 1'b1;
            end
            default:
            begin
                res.status = ST_REJECT;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_head_reg    <= '0;
            free_tail_reg    <= '0;
            free_count_reg   <= FULL_CNT;
            free_written_reg <= '0;
            filled_head_reg  <= '0;
            filled_tail_reg  <= '0;
            filled_count_reg <= '0;
            newest_slot_reg  <= '0;
            held_slot_reg    <= '0;
            held_valid_reg   <= 1'b0;
            stop_reg         <= 1'b0;
        end
        else if (exec)
        begin
            free_head_reg    <= free_head_next;
            free_tail_reg    <= free_tail_next;
            free_count_reg   <= free_count_next;
            free_written_reg <= free_written_next;
            filled_head_reg  <= filled_head_next;
            filled_tail_reg  <= filled_tail_next;
            filled_count_reg <= filled_count_next;
            newest_slot_reg  <= newest_slot_next;
            held_slot_reg    <= held_slot_next;
            held_valid_reg   <= held_valid_next;
            stop_reg         <= stop_next;
        end
    end

    // Array contents.
    always_ff @(posedge clk)
    begin
        if (exec && free_wr_en)
        begin
            free_fifo_reg[free_wr_idx] <= free_wr_slot;
        end
        if (exec && filled_wr_en)
        begin
            filled_fifo_reg[filled_tail_reg] <= filled_wr_slot;
        end
        if (exec && len_wr_en)
        begin
            filled_len_reg[len_wr_idx] <= len_sat;
        end
    end

    // Every slot is free, filled or held, exactly once.
    assert property (@(posedge clk) disable iff (!rst_n)
        (CW'(1) + CW'(0)) == CW'(1) |->
        ({1'b0, free_count_reg} + {1'b0, filled_count_reg} + (CW+1)'(held_valid_reg))
            == (CW+1)'(QUEUE_SLOTS))
        else $error("slot conservation broken");

    // A slot becomes held only through a take.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(held_valid_reg) |-> $past(exec && op == OP_TAKE))
        else $error("held slot appeared without a take");

    // The stop flag is never cleared outside reset.
    assert property (@(posedge clk) disable iff (!rst_n)
        !$fell(stop_reg))
        else $error("stop flag cleared");

    // An overwrite is reported only when no slot is free.
    assert property (@(posedge clk) disable iff (!rst_n)
        (exec && res.status == ST_FULL) |-> (free_count_reg == '0 && filled_count_reg != '0))
        else $error("overwrite reported with a free slot");

endmodule

### rtl/buffer_pool_queue_manager.sv
// Buffer pool queue manager top level: input register, bookkeeping core, result register.
// Depends on bpqm_pkg and bpqm_core.
//
// Tracks a pool of QUEUE_SLOTS buffer slots moving from a free FIFO to a filled FIFO (put),
// to a single held position (take), and back (complete); stop makes a take on an empty
// queue report finished. Every operation produces exactly one result. The block takes one
// operation per cycle and keeps that rate as long as results are taken; each operation
// passes through the input register and then the result register, the result being computed
// combinationally by the core from the operation held in the input register.
// Put lengths above BUFFER_BYTES are saturated to it. The slot output carries the low four
// bits of the slot index.
module buffer_pool_queue_manager #(
    parameter int QUEUE_SLOTS  = 16,
    parameter int BUFFER_BYTES = 4096
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [bpqm_pkg::OP_W-1:0]         operation,
    input  logic [bpqm_pkg::LEN_W-1:0]        length,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [bpqm_pkg::SLOT_W-1:0]       slot,
    output logic [bpqm_pkg::LEN_W-1:0]        length_res,
    output logic [bpqm_pkg::STATUS_W-1:0]     status
);
    import bpqm_pkg::*;

    logic             in_held_reg;
    op_t              op_reg;
    logic [LEN_W-1:0] len_reg;
    logic             out_valid_reg;
    result_t          out_reg;
    result_t          core_res;
    logic             advance;
    logic             exec;
    logic             in_xfer;

    // The pipeline moves when the result register is empty or being taken.
    assign advance  = !out_valid_reg || !out_stall;
    assign exec     = in_held_reg && advance;
    assign in_stall = in_held_reg && !advance;
    assign in_xfer  = in_valid && !in_stall;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_held_reg <= 1'b0;
        end
        else if (in_xfer)
        begin
            in_held_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_held_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            op_reg  <= op_t'(operation);
            len_reg <= length;
        end
    end

    bpqm_core #(
        .QUEUE_SLOTS  (QUEUE_SLOTS),
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .exec   (exec),
        .op     (op_reg),
        .length (len_reg),
        .res    (core_res)
    );

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_held_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (exec)
        begin
            out_reg <= core_res;
        end
    end

    assign out_valid  = out_valid_reg;
    assign slot       = out_reg.slot;
    assign length_res = out_reg.length;
    assign status     = out_reg.status;

endmodule
